### rtl/core/rmq_pkg.sv
// rmq_pkg: shared constants and width helpers for the rotation-matrix to quaternion block.
// No dependencies.
package rmq_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;
  // quotient bits produced by the divider; larger quotients saturate
  localparam int unsigned QUOT_W        = 17;
  localparam int unsigned FIFO_DEPTH    = 2;

  // signed width that holds t and every component for a given fraction width
  function automatic int unsigned rmq_t_w(input int unsigned frac);
    return ((frac > 17) ? frac : 17) + 3;
  endfunction

  // number of root bits of isqrt(t << frac)
  function automatic int unsigned rmq_root_w(input int unsigned frac);
    return (rmq_t_w(frac) + frac + 1) / 2;
  endfunction

endpackage

### rtl/core/rmq_if.sv
// rmq_if: valid/ready channel interfaces for matrix beats and quaternion beats.
// Depends on nothing but fixed 16-bit field widths.
interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_w, q_x, q_y, q_z;
  logic               degenerate;
  modport source (output valid, q_w, q_x, q_y, q_z, degenerate, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, degenerate, output ready);
endinterface

### rtl/core/rmq_front.sv
// rmq_front: registers a matrix beat, picks the Shepperd branch, forms t and the four
// unscaled components. Depends on rmq_pkg and rmq_mat_if.
module rmq_front #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int unsigned EW        = 1 + 5 * rmq_pkg::rmq_t_w(FRAC_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmq_mat_if.sink       mat_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output logic [EW-1:0] push_data_o
);
  import rmq_pkg::*;

  localparam int unsigned TW = rmq_t_w(FRAC_BITS);

  logic                 vld_q, vld_d;
  logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, one;
  logic signed [TW-1:0] t, c0, c1, c2, c3;
  logic [EW-1:0]        data_q;

  assign mat_i.ready = !vld_q || push_ready_i;

  always_comb begin
    a00 = TW'(mat_i.m00); a01 = TW'(mat_i.m01); a02 = TW'(mat_i.m02);
    a10 = TW'(mat_i.m10); a11 = TW'(mat_i.m11); a12 = TW'(mat_i.m12);
    a20 = TW'(mat_i.m20); a21 = TW'(mat_i.m21); a22 = TW'(mat_i.m22);
    one = TW'(1) <<< FRAC_BITS;
    if (a22 < 0) begin
      if (a00 > a11) begin
        t  = one + a00 - a11 - a22;
        c0 = a21 - a12; c1 = t; c2 = a10 + a01; c3 = a02 + a20;
      end else begin
        t  = one - a00 + a11 - a22;
        c0 = a02 - a20; c1 = a10 + a01; c2 = t; c3 = a21 + a12;
      end
    end else begin
      if (a00 < -a11) begin
        t  = one - a00 - a11 + a22;
        c0 = a10 - a01; c1 = a02 + a20; c2 = a21 + a12; c3 = t;
      end else begin
        t  = one + a00 + a11 + a22;
        c0 = t; c1 = a21 - a12; c2 = a02 - a20; c3 = a10 - a01;
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (mat_i.valid && mat_i.ready) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_i.valid && mat_i.ready) begin
      data_q <= {(t <= 0), t, c0, c1, c2, c3};
    end
  end

  assign push_valid_o = vld_q;
  assign push_data_o  = data_q;
endmodule

### rtl/core/rmq_fifo.sv
// rmq_fifo: short queue between the classify front and the arithmetic back.
// Depends on rmq_pkg.
module rmq_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import rmq_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  mem_q [0:FIFO_DEPTH-1];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = push ? ((wptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1) : wptr_q;
    rptr_d = pop  ? ((rptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule

### rtl/core/rmq_back.sv
// rmq_back: pipelined isqrt of t << FRAC_BITS, four pipelined restoring dividers,
// saturation and the output register. Depends on rmq_pkg and rmq_quat_if.
module rmq_back #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int unsigned EW        = 1 + 5 * rmq_pkg::rmq_t_w(FRAC_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [EW-1:0] pop_data_i,
  rmq_quat_if.source    quat_o
);
  import rmq_pkg::*;

  localparam int unsigned TW  = rmq_t_w(FRAC_BITS);
  localparam int unsigned K   = rmq_root_w(FRAC_BITS);
  localparam int unsigned SW  = 2 * K + 1;
  localparam int unsigned NW  = TW + FRAC_BITS + 1;
  localparam int unsigned DW  = ((NW > K + 1 + QUOT_W) ? NW : K + 1 + QUOT_W) + 1;

  logic en;

  // sqrt pipeline
  logic                 sq_vld_q [0:K];
  logic                 sq_deg_q [0:K];
  logic [SW-1:0]        sq_rem_q [0:K];
  logic [SW-1:0]        sq_res_q [0:K];
  logic signed [TW-1:0] sq_c_q   [0:K][0:3];

  // divider pipeline
  logic                 dv_vld_q [0:QUOT_W];
  logic                 dv_deg_q [0:QUOT_W];
  logic [DW-1:0]        dv_den_q [0:QUOT_W];
  logic [DW-1:0]        dv_rem_q [0:QUOT_W][0:3];
  logic [QUOT_W-1:0]    dv_quo_q [0:QUOT_W][0:3];
  logic                 dv_ovf_q [0:QUOT_W][0:3];
  logic                 dv_neg_q [0:QUOT_W][0:3];

  logic                 out_vld_q;
  logic signed [15:0]   out_q_q [0:3];
  logic                 out_deg_q;

  assign en          = !out_vld_q || quat_o.ready;
  assign pop_ready_o = en;

  // stage 0: load from the queue
  logic signed [TW-1:0] in_t;
  assign in_t = pop_data_i[4*TW +: TW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_deg_q[0] <= pop_data_i[EW-1];
      sq_rem_q[0] <= {{(SW-TW){1'b0}}, in_t} << FRAC_BITS;
      sq_res_q[0] <= '0;
      sq_c_q[0][0] <= pop_data_i[3*TW +: TW];
      sq_c_q[0][1] <= pop_data_i[2*TW +: TW];
      sq_c_q[0][2] <= pop_data_i[TW +: TW];
      sq_c_q[0][3] <= pop_data_i[0 +: TW];
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < K; j++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (2 * (K - 1 - j));
    logic [SW-1:0] trial;
    assign trial = sq_res_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_deg_q[j+1] <= sq_deg_q[j];
        sq_c_q[j+1]   <= sq_c_q[j];
        if (sq_rem_q[j] >= trial) begin
          sq_rem_q[j+1] <= sq_rem_q[j] - trial;
          sq_res_q[j+1] <= (sq_res_q[j] >> 1) + BIT;
        end else begin
          sq_rem_q[j+1] <= sq_rem_q[j];
          sq_res_q[j+1] <= sq_res_q[j] >> 1;
        end
      end
    end
  end

  // divider setup: N = (|c| << F) + s, D = 2s
  logic [K-1:0]  root;
  logic [DW-1:0] den;
  assign root = (sq_res_q[K][K-1:0] == '0) ? K'(1) : sq_res_q[K][K-1:0];
  assign den  = {{(DW-K-1){1'b0}}, root, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= sq_vld_q[K];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_setup
    logic [TW-1:0] mag;
    logic [DW-1:0] num;
    assign mag = sq_c_q[K][i][TW-1] ? TW'(-sq_c_q[K][i]) : TW'(sq_c_q[K][i]);
    assign num = ({{(DW-TW){1'b0}}, mag} << FRAC_BITS) + {{(DW-K){1'b0}}, root};

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[0][i] <= num;
        dv_quo_q[0][i] <= '0;
        dv_ovf_q[0][i] <= (num >= (den << QUOT_W));
        dv_neg_q[0][i] <= sq_c_q[K][i][TW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_den_q[0] <= den;
      dv_deg_q[0] <= sq_deg_q[K];
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int unsigned B = QUOT_W - 1 - j;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_den_q[j+1] <= dv_den_q[j];
        dv_deg_q[j+1] <= dv_deg_q[j];
        dv_ovf_q[j+1] <= dv_ovf_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
      end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [DW-1:0] sub;
      assign sub = dv_den_q[j] << B;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (dv_rem_q[j][i] >= sub) begin
            dv_rem_q[j+1][i]    <= dv_rem_q[j][i] - sub;
            dv_quo_q[j+1][i]    <= dv_quo_q[j][i] | (QUOT_W'(1) << B);
          end else begin
            dv_rem_q[j+1][i]    <= dv_rem_q[j][i];
            dv_quo_q[j+1][i]    <= dv_quo_q[j][i];
          end
        end
      end
    end
  end

  // saturate and register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[QUOT_W];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_sat
    logic [QUOT_W-1:0]  quo;
    logic signed [15:0] val;
    assign quo = dv_quo_q[QUOT_W][i];
    always_comb begin
      if (dv_deg_q[QUOT_W]) begin
        val = '0;
      end else if (dv_neg_q[QUOT_W][i]) begin
        if (dv_ovf_q[QUOT_W][i] || (quo > QUOT_W'(32768))) begin
          val = 16'sh8000;
        end else begin
          val = -$signed(quo[15:0]);
        end
      end else begin
        if (dv_ovf_q[QUOT_W][i] || (quo > QUOT_W'(32767))) begin
          val = 16'sh7fff;
        end else begin
          val = $signed(quo[15:0]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        out_q_q[i] <= val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_deg_q <= dv_deg_q[QUOT_W];
    end
  end

  assign quat_o.valid      = out_vld_q;
  assign quat_o.q_w        = out_q_q[0];
  assign quat_o.q_x        = out_q_q[1];
  assign quat_o.q_y        = out_q_q[2];
  assign quat_o.q_z        = out_q_q[3];
  assign quat_o.degenerate = out_deg_q;
endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, Shepperd matrix-to-quaternion converter.
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_fifo and rmq_back.
//
// Usage:
//   mat_i carries one 3x3 matrix per beat (m00..m22, row/col, signed, FRAC_BITS
//   fraction bits). quat_o returns one quaternion beat per matrix, in order:
//   q_w/q_x/q_y/q_z saturated to 16 bits, plus degenerate when the chosen t is
//   not positive (all four components are then zero).
//   Throughput: one matrix per cycle while quat_o is ready.
//   K = ceil((T_W + FRAC_BITS) / 2) is the number of root bits; the sqrt
//   has one root bit per stage, and the restoring dividers have 17 stages.
//   Front: input register with branch select and sums, then a two-entry queue.
//   Back: sqrt pipeline, divider setup, dividers, saturation, output register.
//   A stalled quat_o freezes the back pipeline; the front keeps taking beats
//   until the queue and its own register are full, then drops mat_i.ready.
//   Reset clears all valid bits; no beats are in flight after reset.
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmq_mat_if.sink     mat_i,
  rmq_quat_if.source  quat_o
);
  import rmq_pkg::*;

  localparam int unsigned EW = 1 + 5 * rmq_t_w(FRAC_BITS);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .EW(EW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mat_i        (mat_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rmq_fifo #(.W(EW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS), .EW(EW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .quat_o      (quat_o)
  );

  // degenerate beats carry an all-zero quaternion
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quat_o.valid && quat_o.degenerate) |->
      (quat_o.q_w == '0 && quat_o.q_x == '0 && quat_o.q_y == '0 && quat_o.q_z == '0))
    else $error("degenerate beat with nonzero quaternion");

  // the front holds its beat while the queue is full
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
    else $error("front dropped a beat while queue full");

  // input is only back-pressured when the front register is occupied
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mat_i.ready |-> (push_valid && !push_ready))
    else $error("mat_i.ready low without a full front");
endmodule
